// ===== rtl/core/cpd_pkg.sv =====
// Shared types, codes and helpers for the canonical percent decoder.
`default_nettype none

package cpd_pkg;

    // Widths of the item fields
    localparam int BYTE_W = 8;
    localparam int CODE_W = 3;

    // Queue between the classifier and the decoder
    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Error codes reported with the final byte
    localparam logic [CODE_W-1:0] ERR_NONE     = 3'd0;
    localparam logic [CODE_W-1:0] ERR_NONASCII = 3'd1;
    localparam logic [CODE_W-1:0] ERR_BAD_ESC  = 3'd2;
    localparam logic [CODE_W-1:0] ERR_RESERVED = 3'd3;
    localparam logic [CODE_W-1:0] ERR_NEEDLESS = 3'd4;
    localparam logic [CODE_W-1:0] ERR_BAD_UTF8 = 3'd5;

    // Escape progress
    localparam logic [1:0] ESC_IDLE = 2'd0;
    localparam logic [1:0] ESC_HIGH = 2'd1;
    localparam logic [1:0] ESC_LOW  = 2'd2;

    // Constraint on the second byte of a multibyte sequence
    localparam logic [2:0] RULE_NONE    = 3'd0;
    localparam logic [2:0] RULE_GE_A0   = 3'd1;
    localparam logic [2:0] RULE_LT_A0   = 3'd2;
    localparam logic [2:0] RULE_GE_90   = 3'd3;
    localparam logic [2:0] RULE_LT_90   = 3'd4;

    localparam logic [BYTE_W-1:0] CHAR_PERCENT = 8'h25;
    localparam logic [BYTE_W-1:0] CHAR_TILDE   = 8'h7e;

    // One classified item as it waits in the queue
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
        logic              non_ascii;
        logic              hex_ok;
        logic [3:0]        hex_val;
        logic              is_pct;
        logic              unres;
    } cls_item_t;

    // Unreserved set: A-Z a-z 0-9 - . _ ~
    function automatic logic is_unreserved(input logic [BYTE_W-1:0] c);
        is_unreserved = (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a) ||
                        (c >= 8'h30 && c <= 8'h39) || c == 8'h2d || c == 8'h2e ||
                        c == 8'h5f || c == CHAR_TILDE;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/cpd_if.sv =====
// Valid/ready channel interfaces for the encoded input and decoded output.
`default_nettype none

interface cpd_in_if;
    import cpd_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;
    logic              in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface cpd_out_if;
    import cpd_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              out_byte_valid;
    logic              done_res;
    logic              ok;
    logic [CODE_W-1:0] error_code;

    modport source (output valid, output out_byte, output out_byte_valid,
                    output done_res, output ok, output error_code, input ready);
    modport sink   (input valid, input out_byte, input out_byte_valid,
                    input done_res, input ok, input error_code, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/cpd_front.sv =====
// Front end: accepts encoded bytes and classifies each one.
`default_nettype none

module cpd_front (
    cpd_in_if.sink              in_ch,
    input  logic                full,
    output logic                push,
    output cpd_pkg::cls_item_t  push_data
);
    import cpd_pkg::*;

    logic [BYTE_W-1:0] c;
    logic              is_digit;
    logic              is_upper_hex;

    assign c = in_ch.in_byte;

    // Accept whenever the queue has room
    assign in_ch.ready = !full;
    assign push        = in_ch.valid && !full;

    // Classify the byte
    assign is_digit     = (c >= 8'h30) && (c <= 8'h39);
    assign is_upper_hex = (c >= 8'h41) && (c <= 8'h46);

    always_comb
    begin
        push_data.data      = c;
        push_data.last      = in_ch.in_last;
        push_data.non_ascii = c[BYTE_W-1];
        push_data.hex_ok    = is_digit || is_upper_hex;
        push_data.hex_val   = is_digit ? c[3:0] : (c[3:0] + 4'd9);
        push_data.is_pct    = (c == CHAR_PERCENT);
        push_data.unres     = is_unreserved(c);
    end

endmodule

`default_nettype wire

// ===== rtl/core/cpd_queue.sv =====
// Short queue of classified items between front end and decoder.
`default_nettype none

module cpd_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  cpd_pkg::cls_item_t  push_data,
    output logic                full,
    input  logic                pop,
    output cpd_pkg::cls_item_t  pop_data,
    output logic                empty
);
    import cpd_pkg::*;

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    cls_item_t         slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    assign full     = (count_reg == CNT_FULL);
    assign empty    = (count_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the item
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/cpd_back.sv =====
// Back end: escape decoding, UTF-8 checking, error tracking and result register.
`default_nettype none

module cpd_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                empty,
    input  cpd_pkg::cls_item_t  pop_data,
    output logic                pop,
    cpd_out_if.source           out_ch
);
    import cpd_pkg::*;

    // Decoder state
    logic [1:0]        esc_reg,    esc_next;
    logic [3:0]        nib_reg,    nib_next;
    logic [1:0]        rem_reg,    rem_next;
    logic [2:0]        rule_reg,   rule_next;
    logic [CODE_W-1:0] ferr_reg,   ferr_next;

    // Result register
    logic              ovalid_reg, ovalid_next;
    logic [BYTE_W-1:0] obyte_reg;
    logic              obv_reg;
    logic              odone_reg;
    logic              ook_reg;
    logic [CODE_W-1:0] ocode_reg;

    logic              can_load;
    logic              has_result;
    logic              emit;
    logic [BYTE_W-1:0] dec;
    logic [BYTE_W-1:0] ubyte;
    logic              feed;
    logic              u_ok;
    logic [1:0]        u_rem;
    logic [2:0]        u_rule;
    logic              rule_fail;
    logic [CODE_W-1:0] err;

    assign can_load = !ovalid_reg || out_ch.ready;
    assign pop      = !empty && can_load;
    assign dec      = {nib_reg, pop_data.hex_val};

    // Pick the byte offered to the UTF-8 checker
    assign ubyte = (esc_reg == ESC_LOW) ? dec : pop_data.data;

    // UTF-8 checker on ubyte
    always_comb
    begin
        u_ok   = 1'b1;
        u_rem  = rem_reg;
        u_rule = rule_reg;
        rule_fail = ((rule_reg == RULE_GE_A0) && (ubyte < 8'ha0)) ||
                    ((rule_reg == RULE_LT_A0) && (ubyte >= 8'ha0)) ||
                    ((rule_reg == RULE_GE_90) && (ubyte < 8'h90)) ||
                    ((rule_reg == RULE_LT_90) && (ubyte >= 8'h90));
        if (rem_reg == 2'd0)
        begin
            if (ubyte[7])
            begin
                u_rule = RULE_NONE;
                if (ubyte >= 8'hc2 && ubyte <= 8'hdf)
                begin
                    u_rem = 2'd1;
                end
                else if (ubyte >= 8'he0 && ubyte <= 8'hef)
                begin
                    u_rem = 2'd2;
                    if (ubyte == 8'he0)
                    begin
                        u_rule = RULE_GE_A0;
                    end
                    else if (ubyte == 8'hed)
                    begin
                        u_rule = RULE_LT_A0;
                    end
                end
                else if (ubyte >= 8'hf0 && ubyte <= 8'hf4)
                begin
                    u_rem = 2'd3;
                    if (ubyte == 8'hf0)
                    begin
                        u_rule = RULE_GE_90;
                    end
                    else if (ubyte == 8'hf4)
                    begin
                        u_rule = RULE_LT_90;
                    end
                end
                else
                begin
                    u_ok = 1'b0;
                end
            end
        end
        else if ((ubyte & 8'hc0) != 8'h80 || rule_fail)
        begin
            u_ok = 1'b0;
        end
        else
        begin
            u_rule = RULE_NONE;
            u_rem  = rem_reg - 2'd1;
        end
    end

    // Step the decoder for the item at the head of the queue
    always_comb
    begin
        esc_next  = esc_reg;
        nib_next  = nib_reg;
        rem_next  = rem_reg;
        rule_next = rule_reg;
        ferr_next = ferr_reg;
        err       = ERR_NONE;
        emit      = 1'b0;
        feed      = 1'b0;
        if (ferr_reg == ERR_NONE)
        begin
            if (pop_data.non_ascii)
            begin
                err = ERR_NONASCII;
            end
            else if (esc_reg != ESC_IDLE)
            begin
                if (!pop_data.hex_ok)
                begin
                    err = ERR_BAD_ESC;
                end
                else if (esc_reg == ESC_HIGH)
                begin
                    nib_next = pop_data.hex_val;
                    esc_next = ESC_LOW;
                end
                else
                begin
                    esc_next = ESC_IDLE;
                    nib_next = 4'd0;
                    if (is_unreserved(dec))
                    begin
                        err = ERR_NEEDLESS;
                    end
                    else
                    begin
                        feed = 1'b1;
                    end
                end
            end
            else if (pop_data.is_pct)
            begin
                esc_next = ESC_HIGH;
            end
            else if (!pop_data.unres)
            begin
                err = ERR_RESERVED;
            end
            else
            begin
                feed = 1'b1;
            end
            if (feed)
            begin
                rem_next  = u_rem;
                rule_next = u_rule;
                if (u_ok)
                begin
                    emit = 1'b1;
                end
                else
                begin
                    err = ERR_BAD_UTF8;
                end
            end
            if (err == ERR_NONE && pop_data.last)
            begin
                if (esc_next != ESC_IDLE)
                begin
                    err = ERR_BAD_ESC;
                end
                else if (rem_next != 2'd0)
                begin
                    err = ERR_BAD_UTF8;
                end
            end
            ferr_next = err;
        end
    end

    assign has_result = emit || pop_data.last;

    // Set, hold or drop the result register's valid flag
    always_comb
    begin
        ovalid_next = ovalid_reg;
        if (pop && has_result)
        begin
            ovalid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            ovalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_reg    <= ESC_IDLE;
            nib_reg    <= 4'd0;
            rem_reg    <= 2'd0;
            rule_reg   <= RULE_NONE;
            ferr_reg   <= ERR_NONE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            ovalid_reg <= ovalid_next;
            if (pop)
            begin
                if (pop_data.last)
                begin
                    esc_reg  <= ESC_IDLE;
                    nib_reg  <= 4'd0;
                    rem_reg  <= 2'd0;
                    rule_reg <= RULE_NONE;
                    ferr_reg <= ERR_NONE;
                end
                else
                begin
                    esc_reg  <= esc_next;
                    nib_reg  <= nib_next;
                    rem_reg  <= rem_next;
                    rule_reg <= rule_next;
                    ferr_reg <= ferr_next;
                end
            end
        end
    end

    // Load the result payload
    always_ff @(posedge clk)
    begin
        if (pop && has_result)
        begin
            obyte_reg <= emit ? ubyte : '0;
            obv_reg   <= emit;
            odone_reg <= pop_data.last;
            ook_reg   <= pop_data.last && (ferr_next == ERR_NONE);
            ocode_reg <= pop_data.last ? ferr_next : ERR_NONE;
        end
    end

    assign out_ch.valid          = ovalid_reg;
    assign out_ch.out_byte       = obyte_reg;
    assign out_ch.out_byte_valid = obv_reg;
    assign out_ch.done_res       = odone_reg;
    assign out_ch.ok             = ook_reg;
    assign out_ch.error_code     = ocode_reg;

endmodule

`default_nettype wire

// ===== rtl/core/canonical_percent_decoder.sv =====
// Top level of the canonical percent decoder with strict UTF-8 checking.
// Usage:
//   in_ch carries one encoded byte per item (in_byte) and in_last on the final
//   byte of a string. out_ch carries results: a decoded byte (out_byte_valid)
//   and, on the final byte, done_res with ok and the first error_code.
//   Bytes that finish nothing (a '%' or first hex digit, anything after an
//   error) give no result.
// Path: an accepted byte is written into the two-entry queue; the decoder pops
//   it from the queue head and loads any result into the result register that
//   drives out_ch.
// Throughput: one item per cycle, sustained while out_ch.ready stays high; the
//   decoder state update for one byte is small next-state logic.
// Stall: while a result waits on a low out_ch.ready it holds; the decoder stops
//   popping and the queue absorbs up to two items before in_ch.ready drops.
// Reset: rst_n empties the queue and clears the decoder state and output valid;
//   the block is ready for a new string on the first cycle after reset.
//   After each final byte all decoder state returns to its reset values.
`default_nettype none

module canonical_percent_decoder (
    input  logic        clk,
    input  logic        rst_n,
    cpd_in_if.sink      in_ch,
    cpd_out_if.source   out_ch
);
    import cpd_pkg::*;

    cls_item_t push_data;
    cls_item_t pop_data;
    logic      push;
    logic      pop;
    logic      full;
    logic      empty;

    cpd_front u_front (
        .in_ch     (in_ch),
        .full      (full),
        .push      (push),
        .push_data (push_data)
    );

    cpd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    cpd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .empty    (empty),
        .pop_data (pop_data),
        .pop      (pop),
        .out_ch   (out_ch)
    );

endmodule

`default_nettype wire
